[hdl/sva_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and sequencer states of the voice allocator.
package sva_pkg;

    localparam int VOICE_COUNT = 6;
    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 7;

    localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VCNT_W  = $clog2(VOICE_COUNT + 1);
    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int SCNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int RCNT_W  = $clog2(MAX_RESULTS + 1);

    typedef logic [6:0]             midi_t;
    typedef logic [VOICE_W-1:0]     voice_t;
    typedef logic [VCNT_W-1:0]      vcnt_t;
    typedef logic [VOICE_COUNT-1:0] vmask_t;
    typedef logic [SADDR_W-1:0]     saddr_t;
    typedef logic [SCNT_W-1:0]      scnt_t;
    typedef logic [SCNT_W:0]        ssum_t;
    typedef logic [RCNT_W-1:0]      rcnt_t;

    localparam logic CMD_ON      = 1'b0;
    localparam logic CMD_OFF     = 1'b1;
    localparam logic ACT_TRIGGER = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic  cmd;
        midi_t note;
        midi_t vel;
    } evt_t;

    typedef struct packed {
        logic       action;
        logic [2:0] voice_index;
        midi_t      note_pitch;
        midi_t      note_velocity;
        logic       last;
    } res_t;

    typedef struct packed {
        logic   alloc;
        logic   rel;
        voice_t voice;
        midi_t  note;
        voice_t scan;
    } pool_cmd_t;

    typedef struct packed {
        logic   alloc_ok;
        voice_t alloc_voice;
        logic   scan_busy;
        midi_t  scan_pitch;
    } pool_stat_t;

    typedef struct packed {
        logic   we;
        logic   re;
        saddr_t addr;
        midi_t  wdata;
    } stack_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PON,
        ST_MON,
        ST_SCAN,
        ST_MOFF,
        ST_FRD,
        ST_FWR,
        ST_MRD,
        ST_MTRIG,
        ST_MREL,
        ST_REL
    } seq_state_t;

endpackage

[hdl/sva_note_stack.sv]
`timescale 1ns / 1ps
// Mono note stack memory: one shared address, registered read data.
module sva_note_stack (
    input  logic                clk,
    input  sva_pkg::stack_cmd_t cmd,
    output sva_pkg::midi_t      rdata
);

    sva_pkg::midi_t mem [sva_pkg::STACK_DEPTH];
    sva_pkg::midi_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/sva_voice_pool.sv]
`timescale 1ns / 1ps
// Voice pool: per-voice note table, free voice FIFO and age queue.
module sva_voice_pool (
    input  logic                clk,
    input  logic                rst_n,
    input  sva_pkg::pool_cmd_t  cmd,
    output sva_pkg::pool_stat_t stat
);

    sva_pkg::voice_t free_reg [sva_pkg::VOICE_COUNT];
    sva_pkg::voice_t free_next [sva_pkg::VOICE_COUNT];
    sva_pkg::vcnt_t  free_cnt_reg;
    sva_pkg::vcnt_t  free_cnt_next;
    sva_pkg::voice_t age_reg [sva_pkg::VOICE_COUNT];
    sva_pkg::voice_t age_next [sva_pkg::VOICE_COUNT];
    sva_pkg::vcnt_t  age_cnt_reg;
    sva_pkg::vcnt_t  age_cnt_next;
    sva_pkg::vmask_t busy_reg;
    sva_pkg::vmask_t busy_next;
    sva_pkg::midi_t  pitch_reg [sva_pkg::VOICE_COUNT];
    sva_pkg::midi_t  pitch_next [sva_pkg::VOICE_COUNT];

    logic            steal;
    logic            alloc_ok;
    sva_pkg::voice_t alloc_voice;
    logic            hit_found;
    sva_pkg::vcnt_t  hit_pos;

    assign steal       = (free_cnt_reg == '0) && (age_cnt_reg != '0);
    assign alloc_ok    = (free_cnt_reg != '0) || (age_cnt_reg != '0);
    assign alloc_voice = steal ? age_reg[0] : free_reg[0];

    assign stat.alloc_ok    = alloc_ok;
    assign stat.alloc_voice = alloc_voice;
    assign stat.scan_busy   = busy_reg[cmd.scan];
    assign stat.scan_pitch  = pitch_reg[cmd.scan];

    always_comb
    begin
        hit_found = 1'b0;
        hit_pos   = '0;
        for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
        begin
            if (!hit_found && (sva_pkg::vcnt_t'(i) < age_cnt_reg) && (age_reg[i] == cmd.voice))
            begin
                hit_found = 1'b1;
                hit_pos   = sva_pkg::vcnt_t'(i);
            end
        end
    end

    always_comb
    begin
        free_next     = free_reg;
        free_cnt_next = free_cnt_reg;
        age_next      = age_reg;
        age_cnt_next  = age_cnt_reg;
        busy_next     = busy_reg;
        pitch_next    = pitch_reg;

        if (cmd.alloc && alloc_ok)
        begin
            if (steal)
            begin
                // rotate the oldest voice to the young end
                for (int i = 0; i < sva_pkg::VOICE_COUNT - 1; i++)
                begin
                    age_next[i] = age_reg[i + 1];
                end
                for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
                begin
                    if (sva_pkg::vcnt_t'(i) == age_cnt_reg - 1'b1)
                    begin
                        age_next[i] = alloc_voice;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT - 1; i++)
                begin
                    free_next[i] = free_reg[i + 1];
                end
                free_cnt_next = free_cnt_reg - 1'b1;
                if (age_cnt_reg < sva_pkg::vcnt_t'(sva_pkg::VOICE_COUNT))
                begin
                    for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
                    begin
                        if (sva_pkg::vcnt_t'(i) == age_cnt_reg)
                        begin
                            age_next[i] = alloc_voice;
                        end
                    end
                    age_cnt_next = age_cnt_reg + 1'b1;
                end
            end
            for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
            begin
                if (sva_pkg::voice_t'(i) == alloc_voice)
                begin
                    busy_next[i]  = 1'b1;
                    pitch_next[i] = cmd.note;
                end
            end
        end

        if (cmd.rel)
        begin
            for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
            begin
                if (sva_pkg::voice_t'(i) == cmd.voice)
                begin
                    busy_next[i] = 1'b0;
                end
            end
            if (free_cnt_reg < sva_pkg::vcnt_t'(sva_pkg::VOICE_COUNT))
            begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
                begin
                    if (sva_pkg::vcnt_t'(i) == free_cnt_reg)
                    begin
                        free_next[i] = cmd.voice;
                    end
                end
                free_cnt_next = free_cnt_reg + 1'b1;
            end
            if (hit_found)
            begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT - 1; i++)
                begin
                    if (sva_pkg::vcnt_t'(i) >= hit_pos)
                    begin
                        age_next[i] = age_reg[i + 1];
                    end
                end
                age_cnt_next = age_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
            begin
                free_reg[i] <= sva_pkg::voice_t'(i);
            end
            free_cnt_reg <= sva_pkg::vcnt_t'(sva_pkg::VOICE_COUNT);
            age_cnt_reg  <= '0;
            busy_reg     <= '0;
        end
        else
        begin
            free_reg     <= free_next;
            free_cnt_reg <= free_cnt_next;
            age_cnt_reg  <= age_cnt_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg   <= age_next;
        pitch_reg <= pitch_next;
    end

`ifndef SYNTHESIS
    a_pool_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(free_cnt_reg) + int'(age_cnt_reg)) == sva_pkg::VOICE_COUNT)
        else $error("voice pool lost or duplicated a voice");

    a_release_aged: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rel |-> hit_found)
        else $error("released voice missing from age queue");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.alloc && cmd.rel))
        else $error("allocate and release in the same cycle");
`endif

endmodule

[hdl/sva_seq.sv]
`timescale 1ns / 1ps
// Event sequencer: shared compare unit, voice scan, mono stack control and result emission.
module sva_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mono_mode,
    input  logic                evt_valid,
    output logic                evt_stall,
    input  sva_pkg::evt_t       evt_data,
    input  logic                out_free,
    output logic                emit_valid,
    output sva_pkg::res_t       emit_data,
    output sva_pkg::pool_cmd_t  pool_cmd,
    input  sva_pkg::pool_stat_t pool_stat,
    output sva_pkg::stack_cmd_t stack_cmd,
    input  sva_pkg::midi_t      stack_rdata
);

    sva_pkg::seq_state_t state_reg, state_next;
    sva_pkg::evt_t       evt_reg, evt_next;
    sva_pkg::vmask_t     mask_reg, mask_next;
    sva_pkg::voice_t     scan_reg, scan_next;
    sva_pkg::rcnt_t      rcnt_reg, rcnt_next;
    sva_pkg::scnt_t      mono_cnt_reg, mono_cnt_next;
    sva_pkg::saddr_t     mono_base_reg, mono_base_next;
    sva_pkg::midi_t      mono_pitch_reg, mono_pitch_next;
    sva_pkg::midi_t      mono_vel_reg, mono_vel_next;
    sva_pkg::scnt_t      fi_reg, fi_next;
    sva_pkg::scnt_t      fk_reg, fk_next;

    sva_pkg::midi_t  cmp_a;
    logic            cmp_eq;
    logic            stack_we;
    logic            stack_re;
    sva_pkg::scnt_t  stack_off;
    sva_pkg::midi_t  stack_wdata;
    sva_pkg::ssum_t  stack_sum;
    sva_pkg::voice_t rel_voice;
    sva_pkg::vmask_t rel_onehot;
    sva_pkg::vmask_t rel_rest;
    logic            emit_ok;

    function automatic sva_pkg::res_t make_res(
        input logic            act,
        input sva_pkg::voice_t v,
        input sva_pkg::midi_t  p,
        input sva_pkg::midi_t  vl,
        input logic            fin
    );
        sva_pkg::res_t r;
        r.action        = act;
        r.voice_index   = 3'(v);
        r.note_pitch    = p;
        r.note_velocity = vl;
        r.last          = fin;
        return r;
    endfunction

    // shared compare unit
    always_comb
    begin
        case (state_reg)
            sva_pkg::ST_SCAN: cmp_a = pool_stat.scan_pitch;
            sva_pkg::ST_MOFF: cmp_a = mono_pitch_reg;
            default:          cmp_a = stack_rdata;
        endcase
    end

    assign cmp_eq = (cmp_a == evt_reg.note);

    // ring address: base plus offset, wrapped
    always_comb
    begin
        stack_sum = sva_pkg::ssum_t'(mono_base_reg) + sva_pkg::ssum_t'(stack_off);
        if (stack_sum >= sva_pkg::ssum_t'(sva_pkg::STACK_DEPTH))
        begin
            stack_sum = stack_sum - sva_pkg::ssum_t'(sva_pkg::STACK_DEPTH);
        end
    end

    assign stack_cmd.we    = stack_we;
    assign stack_cmd.re    = stack_re;
    assign stack_cmd.addr  = stack_sum[sva_pkg::SADDR_W-1:0];
    assign stack_cmd.wdata = stack_wdata;

    always_comb
    begin
        rel_voice  = '0;
        rel_onehot = '0;
        for (int i = sva_pkg::VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                rel_voice     = sva_pkg::voice_t'(i);
                rel_onehot    = '0;
                rel_onehot[i] = 1'b1;
            end
        end
        rel_rest = mask_reg & ~rel_onehot;
    end

    assign emit_ok = (rcnt_reg < sva_pkg::rcnt_t'(sva_pkg::MAX_RESULTS));

    always_comb
    begin
        state_next      = state_reg;
        evt_next        = evt_reg;
        mask_next       = mask_reg;
        scan_next       = scan_reg;
        rcnt_next       = rcnt_reg;
        mono_cnt_next   = mono_cnt_reg;
        mono_base_next  = mono_base_reg;
        mono_pitch_next = mono_pitch_reg;
        mono_vel_next   = mono_vel_reg;
        fi_next         = fi_reg;
        fk_next         = fk_reg;
        evt_stall       = 1'b1;
        emit_valid      = 1'b0;
        emit_data       = '0;
        pool_cmd        = '0;
        pool_cmd.note   = evt_reg.note;
        pool_cmd.scan   = scan_reg;
        stack_we        = 1'b0;
        stack_re        = 1'b0;
        stack_off       = '0;
        stack_wdata     = evt_reg.note;

        unique case (state_reg)
            sva_pkg::ST_IDLE:
            begin
                evt_stall = 1'b0;
                if (evt_valid)
                begin
                    evt_next  = evt_data;
                    mask_next = '0;
                    scan_next = '0;
                    rcnt_next = '0;
                    if (evt_data.cmd == sva_pkg::CMD_OFF)
                    begin
                        state_next = sva_pkg::ST_SCAN;
                    end
                    else if (mono_mode)
                    begin
                        state_next = sva_pkg::ST_MON;
                    end
                    else
                    begin
                        state_next = sva_pkg::ST_PON;
                    end
                end
            end

            sva_pkg::ST_PON:
            begin
                if (!pool_stat.alloc_ok)
                begin
                    state_next = sva_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    pool_cmd.alloc = 1'b1;
                    emit_valid     = 1'b1;
                    emit_data      = make_res(sva_pkg::ACT_TRIGGER, pool_stat.alloc_voice,
                                              evt_reg.note, evt_reg.vel, 1'b1);
                    if (pool_stat.alloc_voice == '0)
                    begin
                        mono_pitch_next = evt_reg.note;
                        mono_vel_next   = evt_reg.vel;
                    end
                    state_next = sva_pkg::ST_IDLE;
                end
            end

            sva_pkg::ST_MON:
            begin
                if (out_free)
                begin
                    stack_we = 1'b1;
                    if (mono_cnt_reg == sva_pkg::scnt_t'(sva_pkg::STACK_DEPTH))
                    begin
                        // drop the oldest entry: overwrite it and advance the base
                        stack_off = '0;
                        if (mono_base_reg == sva_pkg::saddr_t'(sva_pkg::STACK_DEPTH - 1))
                        begin
                            mono_base_next = '0;
                        end
                        else
                        begin
                            mono_base_next = mono_base_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        stack_off     = mono_cnt_reg;
                        mono_cnt_next = mono_cnt_reg + 1'b1;
                    end
                    emit_valid      = 1'b1;
                    emit_data       = make_res(sva_pkg::ACT_TRIGGER, '0, evt_reg.note,
                                               evt_reg.vel, 1'b1);
                    mono_pitch_next = evt_reg.note;
                    mono_vel_next   = evt_reg.vel;
                    state_next      = sva_pkg::ST_IDLE;
                end
            end

            sva_pkg::ST_SCAN:
            begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT; i++)
                begin
                    if (sva_pkg::voice_t'(i) == scan_reg)
                    begin
                        mask_next[i] = pool_stat.scan_busy && cmp_eq;
                    end
                end
                if (scan_reg == sva_pkg::voice_t'(sva_pkg::VOICE_COUNT - 1))
                begin
                    if (mono_mode)
                    begin
                        state_next = sva_pkg::ST_MOFF;
                    end
                    else
                    begin
                        mono_cnt_next = '0;
                        state_next    = sva_pkg::ST_REL;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            sva_pkg::ST_MOFF:
            begin
                if (!cmp_eq)
                begin
                    fi_next    = '0;
                    fk_next    = '0;
                    state_next = sva_pkg::ST_FRD;
                end
                else if (mono_cnt_reg > sva_pkg::scnt_t'(1))
                begin
                    mono_cnt_next = mono_cnt_reg - 1'b1;
                    state_next    = sva_pkg::ST_MRD;
                end
                else
                begin
                    mono_cnt_next = '0;
                    state_next    = sva_pkg::ST_MREL;
                end
            end

            sva_pkg::ST_FRD:
            begin
                if (fi_reg == mono_cnt_reg)
                begin
                    mono_cnt_next = fk_reg;
                    state_next    = sva_pkg::ST_REL;
                end
                else
                begin
                    stack_re   = 1'b1;
                    stack_off  = fi_reg;
                    state_next = sva_pkg::ST_FWR;
                end
            end

            sva_pkg::ST_FWR:
            begin
                // keep entries that differ from the released pitch
                if (!cmp_eq)
                begin
                    stack_we    = 1'b1;
                    stack_off   = fk_reg;
                    stack_wdata = stack_rdata;
                    fk_next     = fk_reg + 1'b1;
                end
                fi_next    = fi_reg + 1'b1;
                state_next = sva_pkg::ST_FRD;
            end

            sva_pkg::ST_MRD:
            begin
                stack_re   = 1'b1;
                stack_off  = mono_cnt_reg - 1'b1;
                state_next = sva_pkg::ST_MTRIG;
            end

            sva_pkg::ST_MTRIG:
            begin
                if (out_free)
                begin
                    emit_valid      = 1'b1;
                    emit_data       = make_res(sva_pkg::ACT_TRIGGER, '0, stack_rdata,
                                               mono_vel_reg, mask_reg == '0);
                    mono_pitch_next = stack_rdata;
                    rcnt_next       = rcnt_reg + 1'b1;
                    state_next      = sva_pkg::ST_REL;
                end
            end

            sva_pkg::ST_MREL:
            begin
                if (out_free)
                begin
                    emit_valid = 1'b1;
                    emit_data  = make_res(sva_pkg::ACT_RELEASE, '0, evt_reg.note,
                                          evt_reg.vel, mask_reg == '0);
                    rcnt_next  = rcnt_reg + 1'b1;
                    state_next = sva_pkg::ST_REL;
                end
            end

            sva_pkg::ST_REL:
            begin
                if (mask_reg == '0)
                begin
                    state_next = sva_pkg::ST_IDLE;
                end
                else if (!emit_ok || out_free)
                begin
                    pool_cmd.rel   = 1'b1;
                    pool_cmd.voice = rel_voice;
                    mask_next      = rel_rest;
                    if (emit_ok)
                    begin
                        emit_valid = 1'b1;
                        emit_data  = make_res(sva_pkg::ACT_RELEASE, rel_voice, evt_reg.note,
                                              evt_reg.vel,
                                              (rel_rest == '0) ||
                                              (rcnt_reg == sva_pkg::rcnt_t'(sva_pkg::MAX_RESULTS - 1)));
                        rcnt_next  = rcnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = sva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sva_pkg::ST_IDLE;
            mask_reg       <= '0;
            scan_reg       <= '0;
            rcnt_reg       <= '0;
            mono_cnt_reg   <= '0;
            mono_base_reg  <= '0;
            mono_pitch_reg <= '0;
            mono_vel_reg   <= '0;
            fi_reg         <= '0;
            fk_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_reg       <= mask_next;
            scan_reg       <= scan_next;
            rcnt_reg       <= rcnt_next;
            mono_cnt_reg   <= mono_cnt_next;
            mono_base_reg  <= mono_base_next;
            mono_pitch_reg <= mono_pitch_next;
            mono_vel_reg   <= mono_vel_next;
            fi_reg         <= fi_next;
            fk_reg         <= fk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

`ifndef SYNTHESIS
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> out_free)
        else $error("result emitted while output slot is occupied");

    a_filter_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sva_pkg::ST_FWR) |-> $past(stack_re))
        else $error("stack compare without a preceding read");

    a_alloc_emits: assert property (@(posedge clk) disable iff (!rst_n)
        pool_cmd.alloc |-> (emit_valid && emit_data.last))
        else $error("voice allocated without its trigger transaction");
`endif

endmodule

[hdl/synth_voice_allocator.sv]
`timescale 1ns / 1ps
// Voice allocator top level: config register, result register, sequencer, pool and note stack.
//
//  Channel  Dir  Handshake      Payload
//  evt      in   valid / stall  evt_t: cmd, note, vel
//  res      out  valid / stall  res_t: action, voice_index, note_pitch, note_velocity, last
//  cfg      in   valid / ready  mono_mode, 1 bit
//
// A note-off runs a voice scan through the shared comparator and then releases the matching voices
// one at a time; in mono mode, before those releases, it releases voice 0, retriggers the previous
// note, or filters the released pitch out of the note stack when it is not the sounding one.
// Reset queues voices 0 to VOICE_COUNT-1 as free, empties the age queue and note stack, clears
// mono_mode. A stalled result holds the sequencer; evt_stall stays high until the transaction
// is done.
module synth_voice_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  sva_pkg::evt_t evt_data,
    output logic          res_valid,
    input  logic          res_stall,
    output sva_pkg::res_t res_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    logic                mono_mode_reg, mono_mode_next;
    logic                res_valid_reg, res_valid_next;
    sva_pkg::res_t       res_data_reg, res_data_next;
    logic                out_free;
    logic                emit_valid;
    sva_pkg::res_t       emit_data;
    sva_pkg::pool_cmd_t  pool_cmd;
    sva_pkg::pool_stat_t pool_stat;
    sva_pkg::stack_cmd_t stack_cmd;
    sva_pkg::midi_t      stack_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        mono_mode_next = mono_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            mono_mode_next = cfg_data;
        end

        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (emit_valid)
        begin
            res_valid_next = 1'b1;
            res_data_next  = emit_data;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_mode_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mono_mode_reg <= mono_mode_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    sva_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .mono_mode   (mono_mode_reg),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt_data    (evt_data),
        .out_free    (out_free),
        .emit_valid  (emit_valid),
        .emit_data   (emit_data),
        .pool_cmd    (pool_cmd),
        .pool_stat   (pool_stat),
        .stack_cmd   (stack_cmd),
        .stack_rdata (stack_rdata)
    );

    sva_voice_pool u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pool_cmd),
        .stat  (pool_stat)
    );

    sva_note_stack u_stack (
        .clk   (clk),
        .cmd   (stack_cmd),
        .rdata (stack_rdata)
    );

endmodule
